// File: hw/rtl/h2r_pkg.sv
`default_nettype none

package h2r_pkg;

    // Widths of the transaction fields.
    localparam int unsigned HUE_W  = 16;
    localparam int unsigned CHAN_W = 9;
    localparam int unsigned COL_W  = 8;

    // Adding this multiple of 360 makes every 16-bit signed hue positive
    // without changing its remainder modulo 360.
    localparam logic [16:0] HUE_BIAS   = 17'd33120;
    // floor(65536 / 45): (x >> 3) * RECIP_45 >> 16 is x / 360 or one short.
    localparam logic [10:0] RECIP_45   = 11'd1456;
    localparam logic [9:0]  HUE_WRAP   = 10'd360;
    localparam logic [8:0]  UNIT       = 9'd256;
    localparam logic [7:0]  FULL_SCALE = 8'd255;

    // One 60-degree sector of the colour wheel each, named by where it runs.
    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYAN = 3'd2,
        SEC_CYAN_BLU = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } t_sector;

    typedef struct packed {
        logic signed [HUE_W-1:0] hue_degrees;
        logic [CHAN_W-1:0]       saturation;
        logic [CHAN_W-1:0]       brightness;
    } t_hsv;

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_rgb;

endpackage

`default_nettype wire

// File: hw/rtl/h2r_stream_if.sv
`default_nettype none

interface h2r_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hsv_to_rgb_converter.sv
`default_nettype none

// Channel   Direction  Payload                                   Handshake
// i_hsv     in         hue_degrees s16, saturation u9, brightness u9   valid/ready
// o_rgb     out        red u8, green u8, blue u8                 valid/ready
//
// Six register stages; one transaction enters per clock, unless a stalled
// output has backed every stage up to the input and ready has dropped.
// Reset clears only the stage valid bits. A stalled output holds its result,
// while empty stages further back keep filling, so nothing is lost or repeated.
// Stages: hue biasing and reciprocal multiply, remainder fix, sector split,
// fraction and saturation products, brightness products, channel selection.
module hsv_to_rgb_converter (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    h2r_stream_if.sink    i_hsv,
    h2r_stream_if.source  o_rgb
);

    localparam int unsigned STAGES = 6;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_rdy;

    // Saturation and brightness travel alongside the hue stages.
    logic [7:0]        r_sat [0:3];
    logic [7:0]        r_val [0:3];
    logic [7:0]        w_sat_clamp;
    logic [7:0]        w_val_clamp;

    h2r_pkg::t_sector  w_hue_sector;
    logic [5:0]        w_hue_offset;
    h2r_pkg::t_sector  r_sector4;
    h2r_pkg::t_sector  r_sector5;

    logic [10:0]       w_offset_x17;
    logic [7:0]        w_frac;
    logic [8:0]        w_frac_inv;
    logic [15:0]       w_sat_frac;
    logic [16:0]       w_sat_frac_inv;
    logic [7:0]        r_fall_cut;
    logic [8:0]        r_rise_cut;

    logic [8:0]        w_lo_k;
    logic [8:0]        w_fall_k;
    logic [8:0]        w_rise_k;
    logic [16:0]       w_lo_prod;
    logic [16:0]       w_fall_prod;
    logic [16:0]       w_rise_prod;
    logic [7:0]        r_hi;
    logic [7:0]        r_lo;
    logic [7:0]        r_fall;
    logic [7:0]        r_rise;

    h2r_pkg::t_rgb     n_out;
    h2r_pkg::t_rgb     r_out;

    // A stage loads when it is empty or its successor moves on.
    always_comb begin
        w_rdy[STAGES-1] = !r_vld[STAGES-1] || o_rgb.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_hsv.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_hsv.ready = w_rdy[0];

    h2r_hue_unit u_hue (
        .i_clk    (i_clk),
        .i_adv    (w_rdy[2:0]),
        .i_hue    (i_hsv.data.hue_degrees),
        .o_sector (w_hue_sector),
        .o_offset (w_hue_offset)
    );

    assign w_sat_clamp = i_hsv.data.saturation[8] ? h2r_pkg::FULL_SCALE
                                                  : i_hsv.data.saturation[7:0];
    assign w_val_clamp = i_hsv.data.brightness[8] ? h2r_pkg::FULL_SCALE
                                                  : i_hsv.data.brightness[7:0];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_sat[0] <= w_sat_clamp;
            r_val[0] <= w_val_clamp;
        end
        for (int k = 1; k < 4; k++) begin
            if (w_rdy[k]) begin
                r_sat[k] <= r_sat[k-1];
                r_val[k] <= r_val[k-1];
            end
        end
    end

    // Stage four: f = offset * 255 / 60, which is exactly offset * 17 / 4.
    assign w_offset_x17   = {1'b0, w_hue_offset, 4'd0} + {5'd0, w_hue_offset};
    assign w_frac         = w_offset_x17[9:2];
    assign w_frac_inv     = h2r_pkg::UNIT - {1'b0, w_frac};
    assign w_sat_frac     = {8'd0, r_sat[2]} * {8'd0, w_frac};
    assign w_sat_frac_inv = {9'd0, r_sat[2]} * {8'd0, w_frac_inv};

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_sector4  <= w_hue_sector;
            r_fall_cut <= w_sat_frac[15:8];
            r_rise_cut <= w_sat_frac_inv[16:8];
        end
    end

    // Stage five: scale the brightness by each level. Zero saturation gives
    // all levels equal to the brightness, so grey needs no separate path.
    assign w_lo_k      = h2r_pkg::UNIT - {1'b0, r_sat[3]};
    assign w_fall_k    = h2r_pkg::UNIT - {1'b0, r_fall_cut};
    assign w_rise_k    = h2r_pkg::UNIT - r_rise_cut;
    assign w_lo_prod   = {9'd0, r_val[3]} * {8'd0, w_lo_k};
    assign w_fall_prod = {9'd0, r_val[3]} * {8'd0, w_fall_k};
    assign w_rise_prod = {9'd0, r_val[3]} * {8'd0, w_rise_k};

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_sector5 <= r_sector4;
            r_hi      <= r_val[3];
            r_lo      <= w_lo_prod[15:8];
            r_fall    <= w_fall_prod[15:8];
            r_rise    <= w_rise_prod[15:8];
        end
    end

    // Stage six: place the levels on the channels for the sector.
    always_comb begin
        case (r_sector5)
            h2r_pkg::SEC_RED_YEL: begin
                n_out = '{red: r_hi, green: r_rise, blue: r_lo};
            end
            h2r_pkg::SEC_YEL_GRN: begin
                n_out = '{red: r_fall, green: r_hi, blue: r_lo};
            end
            h2r_pkg::SEC_GRN_CYAN: begin
                n_out = '{red: r_lo, green: r_hi, blue: r_rise};
            end
            h2r_pkg::SEC_CYAN_BLU: begin
                n_out = '{red: r_lo, green: r_fall, blue: r_hi};
            end
            h2r_pkg::SEC_BLU_MAG: begin
                n_out = '{red: r_rise, green: r_lo, blue: r_hi};
            end
            default: begin
                n_out = '{red: r_hi, green: r_lo, blue: r_fall};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_out <= n_out;
        end
    end

    assign o_rgb.valid = r_vld[STAGES-1];
    assign o_rgb.data  = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/h2r_hue_unit.sv
`default_nettype none

// Three register stages: hue modulo 360 by reciprocal multiplication, then a
// single correcting subtract, then the sector and the offset within it.
module h2r_hue_unit (
    input  wire logic                               i_clk,
    input  wire logic [2:0]                         i_adv,
    input  wire logic signed [h2r_pkg::HUE_W-1:0]   i_hue,
    output h2r_pkg::t_sector                        o_sector,
    output logic [5:0]                              o_offset
);

    logic [16:0]      w_biased;
    logic [24:0]      w_quot_prod;
    logic [16:0]      r_biased;
    logic [8:0]       r_quot;

    logic [16:0]      w_quot_360;
    logic [16:0]      w_rem;
    logic [8:0]       n_hue;
    logic [8:0]       r_hue;

    h2r_pkg::t_sector n_sector;
    logic [8:0]       w_base;
    logic [8:0]       w_offset;
    h2r_pkg::t_sector r_sector;
    logic [5:0]       r_offset;

    // Stage one: bias into positive range and estimate the quotient by 360.
    assign w_biased    = {i_hue[h2r_pkg::HUE_W-1], i_hue} + h2r_pkg::HUE_BIAS;
    assign w_quot_prod = {11'd0, w_biased[16:3]} * {14'd0, h2r_pkg::RECIP_45};

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_biased <= w_biased;
            r_quot   <= w_quot_prod[24:16];
        end
    end

    // Stage two: the estimate is exact or one short, so one subtract fixes it.
    assign w_quot_360 = {r_quot, 8'd0} + {2'd0, r_quot, 6'd0} + {3'd0, r_quot, 5'd0}
                      + {5'd0, r_quot, 3'd0};
    assign w_rem      = r_biased - w_quot_360;

    always_comb begin
        if (w_rem[9:0] >= h2r_pkg::HUE_WRAP) begin
            n_hue = 9'(w_rem[9:0] - h2r_pkg::HUE_WRAP);
        end else begin
            n_hue = w_rem[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r_hue <= n_hue;
        end
    end

    // Stage three: sector number and degrees into the sector.
    always_comb begin
        if (r_hue >= 9'd300) begin
            n_sector = h2r_pkg::SEC_MAG_RED;
            w_base   = 9'd300;
        end else if (r_hue >= 9'd240) begin
            n_sector = h2r_pkg::SEC_BLU_MAG;
            w_base   = 9'd240;
        end else if (r_hue >= 9'd180) begin
            n_sector = h2r_pkg::SEC_CYAN_BLU;
            w_base   = 9'd180;
        end else if (r_hue >= 9'd120) begin
            n_sector = h2r_pkg::SEC_GRN_CYAN;
            w_base   = 9'd120;
        end else if (r_hue >= 9'd60) begin
            n_sector = h2r_pkg::SEC_YEL_GRN;
            w_base   = 9'd60;
        end else begin
            n_sector = h2r_pkg::SEC_RED_YEL;
            w_base   = 9'd0;
        end
    end

    assign w_offset = r_hue - w_base;

    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r_sector <= n_sector;
            r_offset <= w_offset[5:0];
        end
    end

    assign o_sector = r_sector;
    assign o_offset = r_offset;

endmodule

`default_nettype wire
